FILE: hdl/mpm_pkg.sv
// Shared types and constants for the masked pixel merge block.
`default_nettype none

package mpm_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned ModeW = 2;

  typedef logic [PixW-1:0] pix_t;

  typedef enum logic [ModeW-1:0] {
    ModeFull = 2'd0,
    Mode420  = 2'd1,
    Mode422  = 2'd2,
    Mode411  = 2'd3
  } mode_e;

  localparam pix_t MaskFull  = 8'hFF;
  localparam pix_t MaskEmpty = 8'h00;
  localparam pix_t RoundLsb  = 8'h80;

endpackage

`default_nettype wire

FILE: hdl/mpm_mask.sv
// Effective mask derivation: sample a in full mode, else rounded pairwise averaging of the samples.
`default_nettype none

module mpm_mask (
  input  mpm_pkg::mode_e mode_i,
  input  mpm_pkg::pix_t  mask_a_i,
  input  mpm_pkg::pix_t  mask_b_i,
  input  mpm_pkg::pix_t  mask_c_i,
  input  mpm_pkg::pix_t  mask_d_i,
  output mpm_pkg::pix_t  mask_o
);
  import mpm_pkg::*;

  function automatic pix_t avg2(pix_t x, pix_t y);
    logic [PixW:0] s;
    s = {1'b0, x} + {1'b0, y} + {{PixW{1'b0}}, 1'b1};
    return s[PixW:1];
  endfunction

  pix_t avg_ab, avg_cd, avg_ac, avg_bd;

  assign avg_ab = avg2(mask_a_i, mask_b_i);
  assign avg_cd = avg2(mask_c_i, mask_d_i);
  assign avg_ac = avg2(mask_a_i, mask_c_i);
  assign avg_bd = avg2(mask_b_i, mask_d_i);

  always_comb begin
    unique case (mode_i)
      ModeFull: mask_o = mask_a_i;
      Mode420:  mask_o = avg2(avg_ac, avg_bd);
      Mode422:  mask_o = avg_ab;
      Mode411:  mask_o = avg2(avg_ab, avg_cd);
      default:  mask_o = mask_a_i;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/mpm_blend.sv
// Alpha blend of source over destination under an 8-bit mask.
`default_nettype none

module mpm_blend (
  input  mpm_pkg::pix_t dst_i,
  input  mpm_pkg::pix_t src_i,
  input  mpm_pkg::pix_t mask_i,
  output mpm_pkg::pix_t pixel_o
);
  import mpm_pkg::*;

  // (256-m)*dst + m*src + 128 rewritten as 256*dst + 128 + m*(src-dst)
  logic signed [PixW:0]     diff;
  logic signed [2*PixW+1:0] mask_ext;
  logic signed [2*PixW+1:0] diff_ext;
  logic signed [2*PixW+1:0] prod;
  logic signed [2*PixW+2:0] sum;

  assign diff     = $signed({1'b0, src_i}) - $signed({1'b0, dst_i});
  assign mask_ext = $signed({{(PixW+2){1'b0}}, mask_i});
  assign diff_ext = {{(PixW+1){diff[PixW]}}, diff};
  assign prod     = mask_ext * diff_ext;
  assign sum  = $signed({3'b000, dst_i, RoundLsb}) + {prod[2*PixW+1], prod};

  always_comb begin
    if (mask_i == MaskFull) begin
      pixel_o = src_i;
    end else if (mask_i == MaskEmpty) begin
      pixel_o = dst_i;
    end else begin
      pixel_o = sum[2*PixW-1:PixW];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/masked_pixel_merge.sv
// Masked pixel merge: two-register pipeline with mask averaging and blend.
//
// Usage: the input channel (in_valid_i/in_ready_o) carries one destination
// pixel, one source pixel and four mask samples per transaction. The output
// channel (out_valid_o/out_ready_i) returns one merged pixel per input
// transaction, in order. The config channel (cfg_valid_i/cfg_ready_o) sets
// the 2-bit subsampling mode; it is always ready and should only be written
// while no pixel is in flight.
// Path: a pixel that is accepted passes the input register, then the result
// register, before it is presented on the output. Throughput is one pixel per
// cycle while the output is not stalled; the logic between the two registers is
// the mask averaging, one 9x9 signed multiply and an add.
// Reset clears both valid flags and sets the mode to full resolution.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready_o then drops until the output is taken. Ready propagates
// backward combinationally through both stages.
`default_nettype none

module masked_pixel_merge (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  mpm_pkg::pix_t      dst_pixel_i,
  input  mpm_pkg::pix_t      src_pixel_i,
  input  mpm_pkg::pix_t      mask_a_i,
  input  mpm_pkg::pix_t      mask_b_i,
  input  mpm_pkg::pix_t      mask_c_i,
  input  mpm_pkg::pix_t      mask_d_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output mpm_pkg::pix_t      merged_pixel_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_data_i
);
  import mpm_pkg::*;

  mode_e mode_q;
  logic  s1_valid_q, out_valid_q;
  pix_t  s1_dst_q, s1_src_q, s1_a_q, s1_b_q, s1_c_q, s1_d_q;
  pix_t  merged_q;
  pix_t  mask, blend;
  logic  s2_ready, s1_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeFull;
    end else if (cfg_valid_i) begin
      mode_q <= mode_e'(cfg_data_i);
    end
  end

  assign s2_ready   = !out_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_dst_q <= dst_pixel_i;
      s1_src_q <= src_pixel_i;
      s1_a_q   <= mask_a_i;
      s1_b_q   <= mask_b_i;
      s1_c_q   <= mask_c_i;
      s1_d_q   <= mask_d_i;
    end
    if (s2_ready && s1_valid_q) begin
      merged_q <= blend;
    end
  end

  mpm_mask u_mask (
    .mode_i   (mode_q),
    .mask_a_i (s1_a_q),
    .mask_b_i (s1_b_q),
    .mask_c_i (s1_c_q),
    .mask_d_i (s1_d_q),
    .mask_o   (mask)
  );

  mpm_blend u_blend (
    .dst_i   (s1_dst_q),
    .src_i   (s1_src_q),
    .mask_i  (mask),
    .pixel_o (blend)
  );

  assign out_valid_o    = out_valid_q;
  assign merged_pixel_o = merged_q;

  // A pending stage-1 transaction moves into the result register when it can.
  a_s1_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_ready) |=> out_valid_q)
    else $error("stage-1 transaction lost");

  // Input backpressure only when both stages are full and output is stalled.
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without cause");

  a_full_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_ready && mode_q == ModeFull && s1_a_q == MaskFull)
      |=> merged_pixel_o == $past(s1_src_q))
    else $error("full mask did not pass source pixel");

  a_empty_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_ready && mode_q == ModeFull && s1_a_q == MaskEmpty)
      |=> merged_pixel_o == $past(s1_dst_q))
    else $error("empty mask did not keep destination pixel");

endmodule

`default_nettype wire
